// ----- rtl/jlvs_pkg.sv -----
// ----------------------------------------------------------------------------
// jlvs_pkg: shared definitions for the jerk limited velocity smoother
// Fixed-point widths, register indexes and the configuration bundle type.
// ----------------------------------------------------------------------------
`default_nettype none

package jlvs_pkg;

   // Q12.20 values: 20 fraction bits.
   localparam int FRAC_BITS = 20;
   localparam int DATA_W    = 32;   // signed velocity and rate words
   localparam int REG_W     = 31;   // unsigned configuration registers
   localparam int CSR_IDX_W = 3;

   // Shared multiplier: signed A (covers a 33-bit difference), B is a
   // zero-extended register value.
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Width of scaled products and intermediate sums.
   localparam int WIDE_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_ACCEL   = 3'd0,
      REG_MAX_DECEL   = 3'd1,
      REG_INV_TAU     = 3'd2,
      REG_MAX_JERK    = 3'd3,
      REG_SETTLE_EPS  = 3'd4,
      REG_TICK_PERIOD = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [REG_W-1:0] accel_limit;
      logic [REG_W-1:0] decel_limit;
      logic [REG_W-1:0] inverse_time_constant;
      logic [REG_W-1:0] jerk_limit;
      logic [REG_W-1:0] snap_window;
      logic [REG_W-1:0] tick_period;
   } jlvs_cfg_type;

endpackage : jlvs_pkg

`default_nettype wire

// ----- rtl/jerk_limited_velocity_smoother.sv -----
// ----------------------------------------------------------------------------
// jerk_limited_velocity_smoother: one-axis jerk limited velocity smoother
// Moves the kept velocity toward each target word through a rate limited
// first-order lag with a jerk limit and a settle snap, in Q12.20.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Payload                                  Handshake
//  req_     in         tdata[31:0] target_velocity (signed)     tvalid/tready
//  rsp_     out        tdata[31:0] smoothed_velocity (signed),  tvalid/tready
//                      tuser[0] settled
//  csr_     in         addr[2:0] register index, wdata[30:0]    we, no wait
//
//  The target is captured at the accepting edge, and the result register is
//  loaded from the settle stage after three passes through the single shared
//  multiplier (lag term, jerk step, motion step) interleaved with the limit,
//  step and settle stages of the sequencer. The input accepts a new word
//  whenever the sequencer is idle, even while the previous result still waits
//  on rsp_tready; a finished word waits in its last stage until the result
//  register is free. Synchronous active-high reset clears the velocity, the
//  applied rate, the configuration registers and the sequencer; no clearing
//  pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module jerk_limited_velocity_smoother
   import jlvs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [DATA_W-1:0]    req_tdata,   // [31:0] target_velocity

   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [DATA_W-1:0]         rsp_tdata,   // [31:0] smoothed_velocity
   output logic [0:0]                rsp_tuser,   // [0] settled

   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_addr,
   input  wire logic [REG_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_REQ,
      S_JERK,
      S_RATE,
      S_MOVE,
      S_STEP,
      S_SETTLE
   } state_type;

   localparam logic signed [WIDE_W-1:0] Q_MAX = WIDE_W'(64'sd2147483647);
   localparam logic signed [WIDE_W-1:0] Q_MIN = -Q_MAX - WIDE_W'(1);

   // Saturate a wide intermediate to the signed 32-bit word range.
   function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > Q_MAX) begin
         r = Q_MAX[DATA_W-1:0];
      end else if (v < Q_MIN) begin
         r = Q_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Clamp v to the symmetric range -lim .. +lim (lim not negative).
   function automatic logic signed [WIDE_W-1:0] clamp_sym(
      input logic signed [WIDE_W-1:0] v,
      input logic signed [WIDE_W-1:0] lim
   );
      logic signed [WIDE_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   jlvs_cfg_type cfg;

   jlvs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ------------------------------------------------------------------------
   // Shared multiplier. The operands are chosen by the sequencer state and
   // the product is registered and is available in the following state.
   // ------------------------------------------------------------------------
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;
   logic signed [PROD_W-1:0]  prod_shr;
   logic signed [WIDE_W-1:0]  prod_q;

   jlvs_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // The arithmetic shift floors, which matches rounding toward minus
   // infinity for negative products.
   assign prod_shr = prod >>> FRAC_BITS;
   assign prod_q   = prod_shr[WIDE_W-1:0];

   // ------------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------------
   state_type                 state_ff,      state_in;
   logic signed [DATA_W-1:0]  cur_ff,        cur_in;        // kept velocity
   logic signed [DATA_W-1:0]  rate_ff,       rate_in;       // applied rate
   logic signed [DATA_W-1:0]  tgt_ff,        tgt_in;
   logic signed [DATA_W:0]    diff_ff,       diff_in;       // target - current
   logic                      tgt_ge_cur_ff, tgt_ge_cur_in;
   logic [REG_W-1:0]          limit_ff,      limit_in;
   logic signed [DATA_W-1:0]  req_rate_ff,   req_rate_in;   // clamped lag rate
   logic signed [DATA_W-1:0]  next_ff,       next_in;       // velocity before snap
   logic                      rsp_valid_ff,  rsp_valid_in;
   logic signed [DATA_W-1:0]  rsp_vel_ff,    rsp_vel_in;
   logic                      rsp_settled_ff, rsp_settled_in;

   // Working signals
   logic signed [DATA_W-1:0]  tgt_word;
   logic signed [DATA_W:0]    tgt_ext;
   logic signed [DATA_W:0]    cur_ext;
   logic signed [DATA_W:0]    tgt_abs;
   logic signed [DATA_W:0]    cur_abs;
   logic                      reversing;
   logic                      slowing;
   logic signed [WIDE_W-1:0]  limit_w;
   logic signed [WIDE_W-1:0]  req_rate_w;
   logic signed [WIDE_W-1:0]  rate_gap;
   logic signed [WIDE_W-1:0]  rate_delta;
   logic signed [WIDE_W-1:0]  next_gap;
   logic signed [WIDE_W-1:0]  next_gap_abs;
   logic                      overshot;
   logic                      settled;
   logic                      accept;
   logic                      out_free;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Direction tests on the incoming word against the kept velocity.
   assign tgt_word  = req_tdata;
   assign tgt_ext   = {tgt_word[DATA_W-1], tgt_word};
   assign cur_ext   = {cur_ff[DATA_W-1], cur_ff};
   assign tgt_abs   = tgt_ext[DATA_W] ? -tgt_ext : tgt_ext;
   assign cur_abs   = cur_ext[DATA_W] ? -cur_ext : cur_ext;
   assign reversing = (cur_ff < 0 && tgt_word > 0) || (cur_ff > 0 && tgt_word < 0);
   assign slowing   = (tgt_abs < cur_abs) || reversing;

   assign limit_w = WIDE_W'(limit_ff);

   // Lag product clamped to the direction's rate limit; it fits a word.
   assign req_rate_w = clamp_sym(prod_q, limit_w);

   // Rate step and settle tests on registered values.
   assign rate_gap     = WIDE_W'(req_rate_ff) - WIDE_W'(rate_ff);
   assign rate_delta   = clamp_sym(rate_gap, prod_q);
   assign next_gap     = WIDE_W'(next_ff) - WIDE_W'(tgt_ff);
   assign next_gap_abs = next_gap[WIDE_W-1] ? -next_gap : next_gap;
   assign overshot     = tgt_ge_cur_ff ? (next_ff > tgt_ff) : (next_ff < tgt_ff);
   assign settled      = overshot || (next_gap_abs < WIDE_W'(cfg.snap_window));

   // Multiplier operand selection.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_REQ: begin
            mul_a = MUL_A_W'(diff_ff);
            mul_b = MUL_B_W'(cfg.inverse_time_constant);
         end
         S_JERK: begin
            mul_a = MUL_A_W'(cfg.jerk_limit);
            mul_b = MUL_B_W'(cfg.tick_period);
         end
         S_MOVE: begin
            mul_a = MUL_A_W'(rate_ff);
            mul_b = MUL_B_W'(cfg.tick_period);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Next-state and datapath logic.
   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      rate_in        = rate_ff;
      tgt_in         = tgt_ff;
      diff_in        = diff_ff;
      tgt_ge_cur_in  = tgt_ge_cur_ff;
      limit_in       = limit_ff;
      req_rate_in    = req_rate_ff;
      next_in        = next_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_vel_in     = rsp_vel_ff;
      rsp_settled_in = rsp_settled_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               tgt_in        = tgt_word;
               diff_in       = tgt_ext - cur_ext;
               tgt_ge_cur_in = tgt_word >= cur_ff;
               limit_in      = slowing ? cfg.decel_limit : cfg.accel_limit;
               state_in      = S_REQ;
            end
         end
         S_REQ: begin
            state_in = S_JERK;
         end
         S_JERK: begin
            // Lag product is ready: clamp it to the direction's rate limit.
            req_rate_in = req_rate_w[DATA_W-1:0];
            state_in    = S_RATE;
         end
         S_RATE: begin
            // Jerk step is ready: move the applied rate toward the request.
            rate_in  = sat_q(WIDE_W'(rate_ff) + rate_delta);
            state_in = S_MOVE;
         end
         S_MOVE: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            next_in  = sat_q(WIDE_W'(cur_ff) + prod_q);
            state_in = S_SETTLE;
         end
         S_SETTLE: begin
            if (out_free) begin
               cur_in         = settled ? tgt_ff : next_ff;
               rate_in        = settled ? '0 : rate_ff;
               rsp_valid_in   = 1'b1;
               rsp_vel_in     = settled ? tgt_ff : next_ff;
               rsp_settled_in = settled;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tgt_ff         <= tgt_in;
      diff_ff        <= diff_in;
      tgt_ge_cur_ff  <= tgt_ge_cur_in;
      limit_ff       <= limit_in;
      req_rate_ff    <= req_rate_in;
      next_ff        <= next_in;
      rsp_vel_ff     <= rsp_vel_in;
      rsp_settled_ff <= rsp_settled_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_vel_ff;
   assign rsp_tuser  = rsp_settled_ff;

`ifndef ASSERT_OFF
   // A settled word leaves the kept velocity on the target.
   a_snap_velocity: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SETTLE && out_free && settled) |=> (cur_ff == tgt_ff))
      else $error("kept velocity differs from target after a settle");

   // A settled word clears the applied rate.
   a_snap_rate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SETTLE && out_free && settled) |=> (rate_ff == '0))
      else $error("applied rate not cleared after a settle");

   // Every accepted word starts the multiplier sequence.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_REQ))
      else $error("accepted word did not start the sequence");

   // A pending result is never overwritten by the next word.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> ($stable(rsp_vel_ff) && $stable(rsp_settled_ff)))
      else $error("pending result overwritten");
`endif

endmodule : jerk_limited_velocity_smoother

`default_nettype wire

// ----- rtl/jlvs_csr.sv -----
// ----------------------------------------------------------------------------
// jlvs_csr: configuration register file
// Six write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvs_csr
   import jlvs_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_addr,
   input  wire logic [REG_W-1:0]     csr_wdata,
   output jlvs_cfg_type              cfg
);

   jlvs_cfg_type cfg_ff;
   jlvs_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            REG_MAX_ACCEL:   cfg_in.accel_limit           = csr_wdata;
            REG_MAX_DECEL:   cfg_in.decel_limit           = csr_wdata;
            REG_INV_TAU:     cfg_in.inverse_time_constant = csr_wdata;
            REG_MAX_JERK:    cfg_in.jerk_limit            = csr_wdata;
            REG_SETTLE_EPS:  cfg_in.snap_window           = csr_wdata;
            REG_TICK_PERIOD: cfg_in.tick_period           = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : jlvs_csr

`default_nettype wire

// ----- rtl/jlvs_mul.sv -----
// ----------------------------------------------------------------------------
// jlvs_mul: shared signed multiplier
// One signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module jlvs_mul
   import jlvs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [MUL_A_W-1:0] op_a,
   input  wire logic signed [MUL_B_W-1:0] op_b,
   output logic signed [PROD_W-1:0]       prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule : jlvs_mul

`default_nettype wire
